/* sv/pes_pkg.sv */
// shared types, constants and the arctangent table of the pose smoother
package pes_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_TRANS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ROT   = 2'd1;

  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd13107;

  localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
  localparam logic [32:0]        DOT_LIMIT = 33'd1073204953;

  localparam int XY_W  = 35;
  localparam int Z_W   = 34;
  localparam int MUL_W = 34;

  localparam logic signed [XY_W-1:0] CORDIC_K = 35'sd652032874;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;

  typedef struct packed {
    logic              meas_ok;
    logic signed [31:0] meas_tx;
    logic signed [31:0] meas_ty;
    logic signed [31:0] meas_tz;
    logic signed [31:0] meas_qx;
    logic signed [31:0] meas_qy;
    logic signed [31:0] meas_qz;
    logic signed [31:0] meas_qw;
  } meas_item_t;

  typedef struct packed {
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
    logic signed [31:0] out_qx;
    logic signed [31:0] out_qy;
    logic signed [31:0] out_qz;
    logic signed [31:0] out_qw;
  } pose_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_FIRST,
    OP_TRANS_MUL,
    OP_TRANS_UPD,
    OP_DOT_MUL,
    OP_DOT_ACC,
    OP_DSIGN,
    OP_LERP_MUL,
    OP_LERP_UPD,
    OP_DSQ_MUL,
    OP_SQRT_S_START,
    OP_ANG_START,
    OP_THETA_CAP,
    OP_THETA_MUL,
    OP_ROT_A_START,
    OP_ROT_B_START,
    OP_W1_CAP,
    OP_WQ_MUL0,
    OP_WQ_MUL1,
    OP_WQ_UPD,
    OP_SS_MUL,
    OP_SS_ACC,
    OP_SQRT_N_START,
    OP_N_CAP,
    OP_UNIT_Q,
    OP_DIV_START,
    OP_DIV_UPD,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic       load_in;
    dp_op_t     op;
    logic [1:0] idx;
  } pes_cmd_t;

  typedef struct packed {
    logic d_big;
    logic n_zero;
    logic cordic_done;
    logic sqrt_done;
    logic div_done;
  } pes_status_t;

  // atan(2^-i) in Q2.30, exact powers of two from step 11 on
  function automatic logic signed [Z_W-1:0] atan_at(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      default: v = Z_W'(1) << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

/* sv/pes_stream_if.sv */
// valid/ready stream channel carrying one item
interface pes_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/pes_cordic.sv */
// iterative cordic, vectoring for the angle and rotation for the sine
module pes_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              vec,
  input  logic signed [pes_pkg::XY_W-1:0]   x0,
  input  logic signed [pes_pkg::XY_W-1:0]   y0,
  input  logic signed [pes_pkg::Z_W-1:0]    z0,
  output logic signed [pes_pkg::XY_W-1:0]   x,
  output logic signed [pes_pkg::XY_W-1:0]   y,
  output logic signed [pes_pkg::Z_W-1:0]    z,
  output logic                              done
);

  localparam int CNT_W = $clog2(pes_pkg::CORDIC_STEPS);

  logic                            busy;
  logic                            mode_vec;
  logic [CNT_W-1:0]                cnt;
  logic signed [pes_pkg::XY_W-1:0] dx, dy;
  logic signed [pes_pkg::Z_W-1:0]  ang;
  logic                            up;

  assign dx  = y >>> cnt;
  assign dy  = x >>> cnt;
  assign ang = pes_pkg::atan_at(5'(cnt));
  // vectoring drives y to zero, rotation drives z to zero
  assign up  = mode_vec ? (y >= 0) : (z < 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(pes_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_vec <= vec;
      x        <= x0;
      y        <= y0;
      z        <= z0;
    end else if (busy) begin
      if (up) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end
    end
  end

endmodule

/* sv/pes_isqrt.sv */
// bit-pair integer square root of a 64-bit value
module pes_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic [31:0] root,
  output logic        done
);

  localparam int CNT_W = $clog2(pes_pkg::SQRT_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      rem;
  logic [63:0]      acc;
  logic [63:0]      bit_v;
  logic [64:0]      trial;

  assign bit_v = 64'd1 << (6'd62 - {cnt, 1'b0});
  assign trial = {1'b0, acc} + {1'b0, bit_v};
  assign root  = acc[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(pes_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= val;
      acc <= '0;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[63:0];
        acc <= (acc >> 1) + bit_v;
      end else begin
        acc <= acc >> 1;
      end
    end
  end

endmodule

/* sv/pes_div.sv */
// restoring divider, 32 quotient bits, numerator high half below the divisor
module pes_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo,
  output logic        done
);

  localparam int CNT_W = $clog2(pes_pkg::DIV_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [31:0]      low;
  logic [31:0]      dvs;
  logic [32:0]      trial;
  logic             fits;

  assign trial = {rem, low[31]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(pes_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[63:32];
      low <= num[31:0];
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      low <= {low[30:0], 1'b0};
      quo <= {quo[30:0], fits};
    end
  end

endmodule

/* sv/pes_datapath.sv */
// pose registers, shared multiplier and the iterative math units
module pes_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pes_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pes_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  pes_pkg::meas_item_t              meas_data,
  input  pes_pkg::pes_cmd_t                cmd,
  output pes_pkg::pes_status_t             st,
  output pes_pkg::pose_item_t              pose_data
);

  logic [16:0] alpha_trans, alpha_rot;
  logic [16:0] wt, wr;

  logic signed [31:0] meas_t [3];
  logic signed [31:0] held_t [3];
  logic signed [31:0] meas_q [4];
  logic signed [31:0] held_q [4];
  logic signed [33:0] r [4];

  logic signed [63:0] acc;
  logic [32:0]        d;
  logic [63:0]        ss;
  logic [31:0]        n;
  logic signed [33:0] theta, b_val, w0, w1;

  logic signed [pes_pkg::MUL_W-1:0]   opa, opb;
  logic signed [2*pes_pkg::MUL_W-1:0] prod, rnd;
  logic signed [32:0] tdiff, qdiff;
  logic signed [63:0] dabs, wsum;
  logic signed [33:0] r_abs;
  logic signed [32:0] qsigned;

  logic                               sq_start, c_start, c_vec, dv_start;
  logic [63:0]                        sq_in, dv_num;
  logic [31:0]                        sq_root, dv_quo;
  logic signed [pes_pkg::XY_W-1:0]    cx0, cy0, cx, cy;
  logic signed [pes_pkg::Z_W-1:0]     cz0, cz;

  function automatic logic signed [31:0] sat_q(input logic signed [32:0] v);
    logic signed [31:0] o;
    if (v > 33'sd1073741824) o = pes_pkg::ONE_Q30;
    else if (v < -33'sd1073741824) o = -pes_pkg::ONE_Q30;
    else o = v[31:0];
    return o;
  endfunction

  assign wt = (alpha_trans > pes_pkg::ALPHA_ONE) ? pes_pkg::ALPHA_ONE : alpha_trans;
  assign wr = (alpha_rot > pes_pkg::ALPHA_ONE) ? pes_pkg::ALPHA_ONE : alpha_rot;

  assign tdiff = {meas_t[cmd.idx][31], meas_t[cmd.idx]} - {held_t[cmd.idx][31], held_t[cmd.idx]};
  assign qdiff = {meas_q[cmd.idx][31], meas_q[cmd.idx]} - {held_q[cmd.idx][31], held_q[cmd.idx]};
  // weighted product rounded to nearest, ties upward
  assign rnd   = (prod + 68'sd32768) >>> 16;
  assign dabs  = acc[63] ? -acc : acc;
  assign wsum  = acc + $signed(prod[63:0]);
  assign r_abs = r[cmd.idx][33] ? -r[cmd.idx] : r[cmd.idx];
  assign qsigned = r[cmd.idx][33] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});

  assign st.d_big  = d > pes_pkg::DOT_LIMIT;
  assign st.n_zero = (n == 32'd0);

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.op)
      pes_pkg::OP_TRANS_MUL: begin
        opa = {tdiff[32], tdiff};
        opb = {17'd0, wt};
      end
      pes_pkg::OP_DOT_MUL: begin
        opa = {{2{held_q[cmd.idx][31]}}, held_q[cmd.idx]};
        opb = {{2{meas_q[cmd.idx][31]}}, meas_q[cmd.idx]};
      end
      pes_pkg::OP_LERP_MUL: begin
        opa = {qdiff[32], qdiff};
        opb = {17'd0, wr};
      end
      pes_pkg::OP_DSQ_MUL: begin
        opa = {1'b0, d};
        opb = {1'b0, d};
      end
      pes_pkg::OP_THETA_MUL: begin
        opa = theta;
        opb = {17'd0, wr};
      end
      pes_pkg::OP_WQ_MUL0: begin
        opa = w0;
        opb = {{2{held_q[cmd.idx][31]}}, held_q[cmd.idx]};
      end
      pes_pkg::OP_WQ_MUL1: begin
        opa = w1;
        opb = {{2{meas_q[cmd.idx][31]}}, meas_q[cmd.idx]};
      end
      pes_pkg::OP_SS_MUL: begin
        opa = r[cmd.idx];
        opb = r[cmd.idx];
      end
      default: ;
    endcase
  end

  assign sq_start = (cmd.op == pes_pkg::OP_SQRT_S_START) ||
                    (cmd.op == pes_pkg::OP_SQRT_N_START);
  assign sq_in    = (cmd.op == pes_pkg::OP_SQRT_S_START) ?
                    (64'd1 << 60) - prod[63:0] : ss;

  assign c_start = (cmd.op == pes_pkg::OP_ANG_START) ||
                   (cmd.op == pes_pkg::OP_ROT_A_START) ||
                   (cmd.op == pes_pkg::OP_ROT_B_START);
  assign c_vec   = (cmd.op == pes_pkg::OP_ANG_START);
  assign cx0     = c_vec ? {2'b00, d} : pes_pkg::CORDIC_K;
  assign cy0     = c_vec ? {3'b000, sq_root} : '0;
  assign cz0     = c_vec ? '0 :
                   ((cmd.op == pes_pkg::OP_ROT_A_START) ? theta - rnd[33:0] : b_val);

  assign dv_start = (cmd.op == pes_pkg::OP_DIV_START);
  assign dv_num   = ({30'd0, r_abs} << 30) + {33'd0, n[31:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_trans <= pes_pkg::ALPHA_RESET;
      alpha_rot   <= pes_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == pes_pkg::REG_ALPHA_TRANS) alpha_trans <= cfg_data;
      if (cfg_idx == pes_pkg::REG_ALPHA_ROT) alpha_rot <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (cmd.load_in) begin
      meas_t[0] <= meas_data.meas_tx;
      meas_t[1] <= meas_data.meas_ty;
      meas_t[2] <= meas_data.meas_tz;
      meas_q[0] <= sat_q({meas_data.meas_qx[31], meas_data.meas_qx});
      meas_q[1] <= sat_q({meas_data.meas_qy[31], meas_data.meas_qy});
      meas_q[2] <= sat_q({meas_data.meas_qz[31], meas_data.meas_qz});
      meas_q[3] <= sat_q({meas_data.meas_qw[31], meas_data.meas_qw});
      acc       <= '0;
    end
    unique case (cmd.op)
      pes_pkg::OP_FIRST: begin
        for (int k = 0; k < 3; k++) held_t[k] <= meas_t[k];
        for (int k = 0; k < 4; k++) held_q[k] <= meas_q[k];
      end
      pes_pkg::OP_TRANS_UPD: held_t[cmd.idx] <= held_t[cmd.idx] + rnd[31:0];
      pes_pkg::OP_DOT_ACC:   acc <= acc + $signed(prod[63:0]);
      pes_pkg::OP_DSIGN: begin
        // take the shorter arc
        if (acc[63]) begin
          for (int k = 0; k < 4; k++) meas_q[k] <= -meas_q[k];
        end
        d  <= dabs[62:30];
        ss <= '0;
      end
      pes_pkg::OP_LERP_UPD:
        r[cmd.idx] <= {{2{held_q[cmd.idx][31]}}, held_q[cmd.idx]} + rnd[33:0];
      pes_pkg::OP_THETA_CAP:   theta <= cz;
      pes_pkg::OP_ROT_A_START: b_val <= rnd[33:0];
      pes_pkg::OP_ROT_B_START: w0 <= cy[33:0];
      pes_pkg::OP_W1_CAP:      w1 <= cy[33:0];
      pes_pkg::OP_WQ_MUL1:     acc <= $signed(prod[63:0]);
      pes_pkg::OP_WQ_UPD:      r[cmd.idx] <= wsum[63:30];
      pes_pkg::OP_SS_ACC:      ss <= ss + prod[63:0];
      pes_pkg::OP_N_CAP:       n <= sq_root;
      pes_pkg::OP_UNIT_Q: begin
        held_q[0] <= '0;
        held_q[1] <= '0;
        held_q[2] <= '0;
        held_q[3] <= pes_pkg::ONE_Q30;
      end
      pes_pkg::OP_DIV_UPD: held_q[cmd.idx] <= sat_q(qsigned);
      pes_pkg::OP_LOAD_OUT: begin
        pose_data.out_tx <= held_t[0];
        pose_data.out_ty <= held_t[1];
        pose_data.out_tz <= held_t[2];
        pose_data.out_qx <= held_q[0];
        pose_data.out_qy <= held_q[1];
        pose_data.out_qz <= held_q[2];
        pose_data.out_qw <= held_q[3];
      end
      default: ;
    endcase
  end

  pes_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (sq_in),
    .root  (sq_root),
    .done  (st.sqrt_done)
  );

  pes_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .vec   (c_vec),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .x     (cx),
    .y     (cy),
    .z     (cz),
    .done  (st.cordic_done)
  );

  pes_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (n),
    .quo   (dv_quo),
    .done  (st.div_done)
  );

endmodule

/* sv/pes_ctrl.sv */
// sequencer that steps the datapath through one pose update
module pes_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 meas_valid,
  input  logic                 meas_ok,
  output logic                 meas_ready,
  output logic                 pose_valid,
  input  logic                 pose_ready,
  output pes_pkg::pes_cmd_t    cmd,
  input  pes_pkg::pes_status_t st
);

  typedef enum logic [4:0] {
    S_IDLE, S_FIRST, S_TRANS, S_DOT, S_DSIGN, S_PICK, S_LERP, S_DSQ, S_SQRT_S,
    S_ANG, S_TMUL, S_ROTA, S_ROTB, S_WQ, S_SS, S_NORM, S_SQRT_N, S_NCHK, S_DIV,
    S_EMIT
  } state_t;

  state_t     state, loop_exit;
  logic [1:0] idx, ph, idx_last, ph_last;
  logic       pose_held;
  logic       meas_fire;

  assign meas_ready = (state == S_IDLE);
  assign meas_fire  = meas_valid && meas_ready;

  always_comb begin
    ph_last   = 2'd1;
    idx_last  = 2'd3;
    loop_exit = S_SS;
    unique case (state)
      S_TRANS: begin
        idx_last  = 2'd2;
        loop_exit = S_DOT;
      end
      S_DOT:   loop_exit = S_DSIGN;
      S_WQ:    ph_last = 2'd2;
      S_SS:    loop_exit = S_NORM;
      default: ;
    endcase
  end

  always_comb begin
    cmd.load_in = meas_fire;
    cmd.idx     = idx;
    cmd.op      = pes_pkg::OP_NONE;
    unique case (state)
      S_FIRST: cmd.op = pes_pkg::OP_FIRST;
      S_TRANS: cmd.op = (ph == 2'd0) ? pes_pkg::OP_TRANS_MUL : pes_pkg::OP_TRANS_UPD;
      S_DOT:   cmd.op = (ph == 2'd0) ? pes_pkg::OP_DOT_MUL : pes_pkg::OP_DOT_ACC;
      S_DSIGN: cmd.op = pes_pkg::OP_DSIGN;
      S_LERP:  cmd.op = (ph == 2'd0) ? pes_pkg::OP_LERP_MUL : pes_pkg::OP_LERP_UPD;
      S_DSQ:   cmd.op = (ph == 2'd0) ? pes_pkg::OP_DSQ_MUL : pes_pkg::OP_SQRT_S_START;
      S_SQRT_S: if (st.sqrt_done) cmd.op = pes_pkg::OP_ANG_START;
      S_ANG:    if (st.cordic_done) cmd.op = pes_pkg::OP_THETA_CAP;
      S_TMUL:  cmd.op = (ph == 2'd0) ? pes_pkg::OP_THETA_MUL : pes_pkg::OP_ROT_A_START;
      S_ROTA:   if (st.cordic_done) cmd.op = pes_pkg::OP_ROT_B_START;
      S_ROTB:   if (st.cordic_done) cmd.op = pes_pkg::OP_W1_CAP;
      S_WQ: begin
        unique case (ph)
          2'd0:    cmd.op = pes_pkg::OP_WQ_MUL0;
          2'd1:    cmd.op = pes_pkg::OP_WQ_MUL1;
          default: cmd.op = pes_pkg::OP_WQ_UPD;
        endcase
      end
      S_SS:    cmd.op = (ph == 2'd0) ? pes_pkg::OP_SS_MUL : pes_pkg::OP_SS_ACC;
      S_NORM:  cmd.op = pes_pkg::OP_SQRT_N_START;
      S_SQRT_N: if (st.sqrt_done) cmd.op = pes_pkg::OP_N_CAP;
      S_NCHK:   if (st.n_zero) cmd.op = pes_pkg::OP_UNIT_Q;
      S_DIV: begin
        if (ph == 2'd0) cmd.op = pes_pkg::OP_DIV_START;
        else if (st.div_done) cmd.op = pes_pkg::OP_DIV_UPD;
      end
      S_EMIT:  if (!pose_valid || pose_ready) cmd.op = pes_pkg::OP_LOAD_OUT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      ph         <= '0;
      pose_held  <= 1'b0;
      pose_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && (!pose_valid || pose_ready)) pose_valid <= 1'b1;
      else if (pose_valid && pose_ready) pose_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          ph  <= '0;
          if (meas_fire) begin
            if (meas_ok) state <= pose_held ? S_TRANS : S_FIRST;
            else if (pose_held) state <= S_EMIT;
          end
        end
        S_FIRST: begin
          pose_held <= 1'b1;
          state     <= S_EMIT;
        end
        S_TRANS, S_DOT, S_LERP, S_WQ, S_SS: begin
          if (ph == ph_last) begin
            ph <= '0;
            if (idx == idx_last) begin
              idx   <= '0;
              state <= loop_exit;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_DSIGN: state <= S_PICK;
        S_PICK:  state <= st.d_big ? S_LERP : S_DSQ;
        S_DSQ: begin
          if (ph == 2'd0) ph <= 2'd1;
          else begin
            ph    <= '0;
            state <= S_SQRT_S;
          end
        end
        S_SQRT_S: if (st.sqrt_done) state <= S_ANG;
        S_ANG:    if (st.cordic_done) state <= S_TMUL;
        S_TMUL: begin
          if (ph == 2'd0) ph <= 2'd1;
          else begin
            ph    <= '0;
            state <= S_ROTA;
          end
        end
        S_ROTA:   if (st.cordic_done) state <= S_ROTB;
        S_ROTB:   if (st.cordic_done) state <= S_WQ;
        S_NORM:   state <= S_SQRT_N;
        S_SQRT_N: if (st.sqrt_done) state <= S_NCHK;
        S_NCHK:   state <= st.n_zero ? S_EMIT : S_DIV;
        S_DIV: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (st.div_done) begin
            ph <= '0;
            if (idx == 2'd3) state <= S_EMIT;
            else idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (!pose_valid || pose_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // once a pose is stored it stays stored
  a_held_sticky: assert property (@(posedge clk) disable iff (rst)
    pose_held |=> pose_held)
    else $error("stored pose flag dropped");

  // a failed item with nothing stored produces no work
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    meas_fire && !meas_ok && !pose_held |=> state == S_IDLE && !$rose(pose_valid))
    else $error("failed item before first pose was not dropped");

  // the output register is only overwritten when free or being taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == pes_pkg::OP_LOAD_OUT |-> !pose_valid || pose_ready)
    else $error("result overwritten while still pending");

  // a fresh item always leaves a pose stored
  a_fresh_held: assert property (@(posedge clk) disable iff (rst)
    meas_fire && meas_ok |=> ##1 pose_held)
    else $error("fresh item did not store a pose");

endmodule

/* sv/pose_ema_slerp_smoother_core.sv */
// pose smoother top level: sequencer plus datapath
//
//   channel   dir  handshake          payload
//   meas      in   valid/ready        meas_ok, meas_tx..tz, meas_qx..qw
//   pose      out  valid/ready        out_tx..tz, out_qx..qw
//   cfg       in   cfg_we, no stall   cfg_idx, cfg_data (alpha_trans, alpha_rot)
//
// one item at a time; the length of an update is set by the shared iterative square
// root (32 steps), cordic (30 steps, run three times) and divider (32 steps per
// quaternion component).
// synchronous reset clears the stored pose and loads both weights with 13107.
// a new item is taken while the last result still waits; a stalled result holds
// back only the hand-off of the next one.
module pose_ema_slerp_smoother_core (
  input  logic                           clk,
  input  logic                           rst,
  pes_stream_if.sink                     meas,
  pes_stream_if.source                   pose,
  input  logic                           cfg_we,
  input  logic [pes_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pes_pkg::CFG_DATA_W-1:0] cfg_data
);

  pes_pkg::pes_cmd_t    cmd;
  pes_pkg::pes_status_t st;
  pes_pkg::meas_item_t  meas_item;
  pes_pkg::pose_item_t  pose_item;

  assign meas_item = meas.data;
  assign pose.data = pose_item;

  pes_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas.valid),
    .meas_ok    (meas_item.meas_ok),
    .meas_ready (meas.ready),
    .pose_valid (pose.valid),
    .pose_ready (pose.ready),
    .cmd        (cmd),
    .st         (st)
  );

  pes_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .meas_data (meas_item),
    .cmd       (cmd),
    .st        (st),
    .pose_data (pose_item)
  );

endmodule
